@@ sv/fixed_point_alu_q24_8_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Q24.8 fixed-point ALU
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// Assertion on an explicit clock and active-low reset
`define FPA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset
`define FPA_ASSERT(lbl, prop, msg) \
    `FPA_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

@@ sv/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Constants, opcodes and the pipeline record of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACT_BITS = 8;
    // Width of the doubled divide numerator, one quotient bit per cell
    localparam int NW = 32 + FRACT_BITS + 1;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_EQ       = 4'd4;
    localparam logic [3:0] OP_NE       = 4'd5;
    localparam logic [3:0] OP_GT       = 4'd6;
    localparam logic [3:0] OP_LT       = 4'd7;
    localparam logic [3:0] OP_GE       = 4'd8;
    localparam logic [3:0] OP_LE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_TO_INT   = 4'd14;
    localparam logic [3:0] OP_FROM_INT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]    cmd;
        logic          neg;      // sign of the saturating result
        logic          use_sat;  // final rounding and saturation apply
        logic [31:0]   res;      // result of the simple operations
        logic          cmp;
        logic [1:0]    status;
        logic [63:0]   prod;     // product, or shifted magnitude for from_int
        logic [31:0]   den;
        logic [31:0]   rem;
        logic [NW-1:0] nq;       // numerator bits out at the top, quotient in below
    } fpa_item_t;

endpackage

@@ sv/fixed_point_alu_q24_8.sv @@
// Stages: the chain of one-bit divide cells plus the output register.
// Throughput: one request per cycle while the output is not stalled; every cell has its own slot and ready.
// Reset: aresetn, synchronous active low, empties every slot; no other state.
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Pipelined signed fixed-point ALU on raw 32-bit operands.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 import fpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[3:0], operand_a[35:4], operand_b[67:36], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_value[31:0], compare_true[32], status[34:33], zeros
);

    fpa_item_t   items [0:NW];
    logic        valids [0:NW];
    logic        readys [0:NW];
    logic [31:0] result_value;
    logic        compare_true;
    logic [1:0]  status;

    fpa_front u_front (
        .cmd       (s_tdata[3:0]),
        .operand_a (s_tdata[35:4]),
        .operand_b (s_tdata[67:36]),
        .item      (items[0])
    );

    assign valids[0] = s_tvalid;
    assign s_tready  = readys[0];

    for (genvar i = 0; i < NW; i++) begin : g_cell
        fpa_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valids[i]),
            .in_ready  (readys[i]),
            .in_item   (items[i]),
            .out_valid (valids[i+1]),
            .out_ready (readys[i+1]),
            .out_item  (items[i+1])
        );
    end

    fpa_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (valids[NW]),
        .in_ready     (readys[NW]),
        .in_item      (items[NW]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result_value (result_value),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_tdata = {5'd0, status, compare_true, result_value};

endmodule

@@ sv/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Decode of one request: simple operations, magnitudes and the multiply.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
    input  logic [3:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output fpa_item_t   item
);

    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic               lt;
    logic               eq;

    assign sa = operand_a;
    assign sb = operand_b;
    assign ma = sa[31] ? (32'd0 - operand_a) : operand_a;
    assign mb = sb[31] ? (32'd0 - operand_b) : operand_b;
    assign lt = sa < sb;
    assign eq = operand_a == operand_b;

    always_comb begin
        item         = '0;
        item.cmd     = cmd;
        item.den     = mb;
        item.rem     = '0;
        item.nq      = {1'b0, ma, {FRACT_BITS{1'b0}}} << 1;
        item.neg     = sa[31] ^ sb[31];
        item.prod    = 64'(ma) * 64'(mb);
        unique case (cmd)
            OP_ADD:    item.res = operand_a + operand_b;
            OP_SUB:    item.res = operand_a - operand_b;
            OP_MUL:    item.use_sat = 1'b1;
            OP_DIV: begin
                if (mb == 32'd0) begin
                    item.status = ST_DIV0;
                end else begin
                    item.use_sat = 1'b1;
                end
            end
            OP_EQ:     item.cmp = eq;
            OP_NE:     item.cmp = !eq;
            OP_GT:     item.cmp = !lt && !eq;
            OP_LT:     item.cmp = lt;
            OP_GE:     item.cmp = !lt;
            OP_LE:     item.cmp = lt || eq;
            OP_MIN:    item.res = lt ? operand_a : operand_b;
            OP_MAX:    item.res = (!lt && !eq) ? operand_a : operand_b;
            OP_INC:    item.res = operand_a + 32'd1;
            OP_DEC:    item.res = operand_a - 32'd1;
            OP_TO_INT: item.res = 32'(sa >>> FRACT_BITS);
            OP_FROM_INT: begin
                item.use_sat = 1'b1;
                item.neg     = sa[31];
                item.prod    = 64'(ma) << FRACT_BITS;
            end
            default:   item.res = '0;
        endcase
    end

endmodule

@@ sv/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring divide step and one pipeline slot with its own handshake.
// ----------------------------------------------------------------------------
module fpa_div_cell import fpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  fpa_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output fpa_item_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    fpa_item_t item_reg;
    fpa_item_t item_next;
    logic [32:0] r2;
    logic        qbit;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        r2        = {in_item.rem, in_item.nq[NW-1]};
        qbit      = r2 >= {1'b0, in_item.den};
        item_next = in_item;
        item_next.rem = qbit ? 32'(r2 - {1'b0, in_item.den}) : r2[31:0];
        item_next.nq  = {in_item.nq[NW-2:0], qbit};
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the slot while downstream stalls
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Rounding, saturation and the output register of the result stream.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_q24_8_defines.svh"

module fpa_back import fpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  fpa_item_t   in_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] result_value,
    output logic        compare_true,
    output logic [1:0]  status
);

    localparam logic [63:0] HALF    = (64'd1 << FRACT_BITS) >> 1;
    localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_MAG = 64'h0000_0000_8000_0000;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] res_reg;
    logic [31:0] res_next;
    logic        cmp_reg;
    logic        cmp_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [63:0] mag;
    logic [NW:0] qdiv;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        qdiv = ({1'b0, in_item.nq} + (NW+1)'(1)) >> 1;
        if (in_item.cmd == OP_DIV) begin
            mag = 64'(qdiv);
        end else if (in_item.cmd == OP_MUL) begin
            mag = (in_item.prod + HALF) >> FRACT_BITS;
        end else begin
            mag = in_item.prod;
        end
        res_next    = in_item.res;
        cmp_next    = in_item.cmp;
        status_next = in_item.status;
        if (in_item.use_sat) begin
            if (in_item.neg) begin
                if (mag > NEG_MAG) begin
                    res_next    = NEG_MAG[31:0];
                    status_next = ST_OVF;
                end else begin
                    res_next = 32'(64'd0 - mag);
                end
            end else if (mag > POS_MAX) begin
                res_next    = POS_MAX[31:0];
                status_next = ST_OVF;
            end else begin
                res_next = mag[31:0];
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            res_reg    <= res_next;
            cmp_reg    <= cmp_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid     = valid_reg;
    assign result_value = res_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;

    `FPA_ASSERT(a_cmp_zero, (m_tvalid && compare_true) |-> (result_value == 32'd0), "cmp nonzero")
    `FPA_ASSERT(a_status_code, m_tvalid |-> (status != 2'd3), "bad status")
    `FPA_ASSERT(a_div0_zero, (m_tvalid && status == ST_DIV0) |-> (result_value == 32'd0), "div0")

endmodule
